@@ rtl/b62sc_pkg.sv @@
package b62sc_pkg;

  localparam int unsigned DigitCount = 11;
  localparam int unsigned DigitW = 6;
  localparam int unsigned ValueW = 64;
  localparam int unsigned SerialW = 63;
  localparam int unsigned CharW = 8;
  localparam int unsigned PosW = 4;
  localparam int unsigned RowDepth = DigitCount + 1;
  localparam int unsigned RowCntW = 4;
  localparam int unsigned PendW = 3;
  localparam int unsigned FeedW = DigitCount * DigitW;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 80;

  localparam logic [CharW-1:0] Underscore = 8'h5F;
  localparam logic [SerialW-1:0] SerialMin = 63'd3844;
  localparam logic [SerialW-1:0] SerialMax = 63'd8392993658683402240;
  localparam logic [DigitW-1:0] BadDigit = 6'd62;

  localparam logic OpEncode = 1'b0;
  localparam logic OpDecode = 1'b1;
  localparam logic KindChar = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNil = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  localparam logic [3:0] ConsumedOk = 4'd12;
  localparam logic [3:0] ConsumedNil = 4'd2;
  localparam logic [3:0] ConsumedNone = 4'd0;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              zero;
    logic [DigitW-1:0] carry;
  } link_t;

  typedef struct packed {
    logic copy;
    logic zero;
  } chain_done_t;

  typedef struct packed {
    logic               chk;
    logic [1:0]         status;
    logic [SerialW-1:0] val;
  } verdict_t;

  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 6'd10) begin
      c = 8'h30 + {2'b00, d};
    end else if (d < 6'd36) begin
      c = 8'h61 + {2'b00, d} - 8'd10;
    end else begin
      c = 8'h41 + {2'b00, d} - 8'd36;
    end
    return c;
  endfunction

  function automatic logic [DigitW-1:0] digit_val(logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = 6'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = 6'(c - 8'h41 + 8'd36);
    end else begin
      d = BadDigit;
    end
    return d;
  endfunction

endpackage

@@ rtl/b62sc_cell.sv @@
module b62sc_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  b62sc_pkg::link_t                link_i,
  output b62sc_pkg::link_t                link_o,
  output logic [b62sc_pkg::DigitW-1:0]    digit_o
);

  b62sc_pkg::link_t link_q;
  logic [b62sc_pkg::DigitW-1:0] acc_q, hold_q;
  logic [b62sc_pkg::DigitW-1:0] base, rem, carry_out;
  logic [7:0] sum;
  logic [1:0] quo;

  // Digit times 64 plus carry, reduced modulo 62; the carry out is the quotient.
  always_comb begin
    base = link_i.first ? '0 : acc_q;
    sum = {1'b0, base, 1'b0} + {2'b00, link_i.carry};
    if (sum >= 8'd124) begin
      quo = 2'd2;
      rem = 6'(sum - 8'd124);
    end else if (sum >= 8'd62) begin
      quo = 2'd1;
      rem = 6'(sum - 8'd62);
    end else begin
      quo = 2'd0;
      rem = sum[5:0];
    end
    carry_out = base + {4'b0000, quo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else if (en_i) begin
      link_q.valid <= link_i.valid;
      link_q.first <= link_i.first;
      link_q.last <= link_i.last;
      link_q.zero <= link_i.zero;
      link_q.carry <= carry_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && link_i.valid) begin
      acc_q <= rem;
      if (link_i.last) begin
        hold_q <= rem;
      end
    end
  end

  assign link_o = link_q;
  assign digit_o = hold_q;

endmodule

@@ rtl/b62sc_enc_chain.sv @@
module b62sc_enc_chain (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 start_i,
  input  logic [b62sc_pkg::ValueW-1:0]                         value_i,
  input  logic                                                 row_empty_i,
  output logic                                                 ready_o,
  output b62sc_pkg::chain_done_t                               done_o,
  output logic [b62sc_pkg::DigitCount-1:0][b62sc_pkg::DigitW-1:0] digits_o
);

  localparam logic [3:0] LastChunk = 4'(b62sc_pkg::DigitCount - 1);

  logic busy_q, zero_q, en;
  logic [3:0] cnt_q;
  logic [b62sc_pkg::FeedW-1:0] sh_q;
  b62sc_pkg::link_t links [b62sc_pkg::DigitCount+1];
  b62sc_pkg::link_t tail;

  assign tail = links[b62sc_pkg::DigitCount];
  assign en = !(tail.valid && tail.last && !row_empty_i);
  assign ready_o = !busy_q || (cnt_q == LastChunk && en);

  assign done_o.copy = tail.valid && tail.last && row_empty_i;
  assign done_o.zero = tail.zero;

  assign links[0].valid = busy_q;
  assign links[0].first = (cnt_q == '0);
  assign links[0].last = (cnt_q == LastChunk);
  assign links[0].zero = zero_q;
  assign links[0].carry = sh_q[b62sc_pkg::FeedW-1 -: b62sc_pkg::DigitW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (en && busy_q) begin
      if (cnt_q == LastChunk) begin
        busy_q <= 1'b0;
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= {{(b62sc_pkg::FeedW - b62sc_pkg::ValueW){1'b0}}, value_i};
      zero_q <= (value_i == '0);
    end else if (en && busy_q) begin
      sh_q <= {sh_q[b62sc_pkg::FeedW-b62sc_pkg::DigitW-1:0], {b62sc_pkg::DigitW{1'b0}}};
    end
  end

  for (genvar j = 0; j < b62sc_pkg::DigitCount; j++) begin : g_cell
    b62sc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .link_i  (links[j]),
      .link_o  (links[j+1]),
      .digit_o (digits_o[j])
    );
  end

endmodule

@@ rtl/b62sc_decoder.sv @@
module b62sc_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [b62sc_pkg::CharW-1:0]   char_i,
  input  logic                          take_i,
  output logic                          fires_o,
  output b62sc_pkg::verdict_t           verdict_o
);

  localparam logic [b62sc_pkg::PosW-1:0] LastPos = 4'(b62sc_pkg::DigitCount);

  logic [b62sc_pkg::PosW-1:0] pos_q, pos_d, pos;
  logic [b62sc_pkg::SerialW-1:0] acc_q, acc_d, nxt;
  logic [b62sc_pkg::DigitW-1:0] dv;
  logic is_dec;

  always_comb begin
    pos = (pos_q > LastPos) ? '0 : pos_q;
    dv = b62sc_pkg::digit_val(char_i);
    is_dec = (char_i >= 8'h30) && (char_i <= 8'h39);
    nxt = 63'({acc_q, 6'b000000}) - 63'({acc_q, 1'b0}) + 63'(dv);
    pos_d = pos;
    acc_d = acc_q;
    fires_o = 1'b0;
    verdict_o.chk = 1'b0;
    verdict_o.status = b62sc_pkg::StMalformed;
    verdict_o.val = '0;
    unique case (pos)
      4'd0: begin
        if (char_i == b62sc_pkg::Underscore) begin
          pos_d = 4'd1;
          acc_d = '0;
        end else begin
          fires_o = 1'b1;
        end
      end
      4'd1: begin
        if (char_i == b62sc_pkg::Underscore) begin
          fires_o = 1'b1;
          verdict_o.status = b62sc_pkg::StNil;
        end else if (is_dec) begin
          acc_d = 63'(dv);
          pos_d = 4'd2;
        end else begin
          fires_o = 1'b1;
        end
      end
      default: begin
        if (dv == b62sc_pkg::BadDigit) begin
          fires_o = 1'b1;
        end else if (pos == LastPos) begin
          fires_o = 1'b1;
          verdict_o.chk = 1'b1;
          verdict_o.val = nxt;
        end else begin
          acc_d = nxt;
          pos_d = pos + 4'd1;
        end
      end
    endcase
    if (fires_o) begin
      pos_d = '0;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

@@ rtl/base62_serial_codec_unit.sv @@
// Encode: after the request is taken the characters leave one per cycle while the output is
// not stalled; a nonzero encode gives twelve characters through the single output character
// port and a zero encode two, and the chain can take a new value before its cells are through.
// Decode: one character per cycle while no verdict is held back; a verdict passes the verdict
// and output registers, once the characters of earlier encodes have been delivered.
// Reset clears the decoder position and accumulator and every valid flag at once.
module base62_serial_codec_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value [63:0], in_char [71:64]
  input  logic [b62sc_pkg::InDataW-1:0]        s_axis_tdata,
  // operation [0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_char [7:0], decoded_value [70:8], status [72:71], consumed [76:73], zero [79:77]
  output logic [b62sc_pkg::OutDataW-1:0]       m_axis_tdata,
  // kind [0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int unsigned PendW = b62sc_pkg::PendW;
  localparam int unsigned RowCntW = b62sc_pkg::RowCntW;

  logic [b62sc_pkg::ValueW-1:0] value;
  logic [b62sc_pkg::CharW-1:0] in_char;
  logic enc_ready, enc_take, dec_take, fires, row_empty, out_free, pop;
  b62sc_pkg::chain_done_t done;
  b62sc_pkg::verdict_t verdict, vq_q;
  logic vq_v_q;
  logic [b62sc_pkg::DigitCount-1:0][b62sc_pkg::DigitW-1:0] digits;
  logic [b62sc_pkg::PendW-1:0] pend_q;
  logic [b62sc_pkg::RowDepth-1:0][b62sc_pkg::CharW-1:0] row_q;
  logic [b62sc_pkg::RowCntW-1:0] cnt_q;
  logic in_range;

  logic out_v_q, kind_q, last_q;
  logic [b62sc_pkg::CharW-1:0] char_q;
  logic [b62sc_pkg::SerialW-1:0] val_q;
  logic [1:0] status_q;
  logic [3:0] cons_q;

  assign value = s_axis_tdata[b62sc_pkg::ValueW-1:0];
  assign in_char = s_axis_tdata[b62sc_pkg::InDataW-1 -: b62sc_pkg::CharW];
  assign row_empty = (cnt_q == '0);

  always_comb begin
    if (s_axis_tuser == b62sc_pkg::OpDecode) begin
      s_axis_tready = !fires || ((!vq_v_q || out_free) && pend_q == '0 && row_empty);
    end else begin
      s_axis_tready = enc_ready;
    end
  end

  assign enc_take = s_axis_tvalid && s_axis_tready && s_axis_tuser == b62sc_pkg::OpEncode;
  assign dec_take = s_axis_tvalid && s_axis_tready && s_axis_tuser == b62sc_pkg::OpDecode;

  b62sc_enc_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (enc_take),
    .value_i     (value),
    .row_empty_i (row_empty),
    .ready_o     (enc_ready),
    .done_o      (done),
    .digits_o    (digits)
  );

  b62sc_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .char_i    (in_char),
    .take_i    (dec_take),
    .fires_o   (fires),
    .verdict_o (verdict)
  );

  assign out_free = !out_v_q || m_axis_tready;
  assign pop = out_free && !vq_v_q && !row_empty;
  assign in_range = (vq_q.val > b62sc_pkg::SerialMin) && (vq_q.val < b62sc_pkg::SerialMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q <= '0;
      vq_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      pend_q <= pend_q + PendW'(enc_take) - PendW'(done.copy);
      if (done.copy) begin
        cnt_q <= done.zero ? RowCntW'(2) : RowCntW'(b62sc_pkg::RowDepth);
      end else if (pop) begin
        cnt_q <= cnt_q - RowCntW'(1);
      end
      if (dec_take && fires) begin
        vq_v_q <= 1'b1;
      end else if (out_free) begin
        vq_v_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= vq_v_q || !row_empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_take && fires) begin
      vq_q <= verdict;
    end
    if (done.copy) begin
      row_q[0] <= b62sc_pkg::Underscore;
      if (done.zero) begin
        row_q[1] <= b62sc_pkg::Underscore;
      end else begin
        for (int k = 1; k < b62sc_pkg::RowDepth; k++) begin
          row_q[k] <= b62sc_pkg::digit_char(digits[b62sc_pkg::DigitCount - k]);
        end
      end
    end else if (pop) begin
      for (int k = 0; k < b62sc_pkg::RowDepth - 1; k++) begin
        row_q[k] <= row_q[k+1];
      end
    end
    if (out_free) begin
      if (vq_v_q) begin
        kind_q <= b62sc_pkg::KindVerdict;
        char_q <= '0;
        last_q <= 1'b1;
        if (!vq_q.chk) begin
          status_q <= vq_q.status;
          val_q <= '0;
          cons_q <= (vq_q.status == b62sc_pkg::StNil) ? b62sc_pkg::ConsumedNil
                                                      : b62sc_pkg::ConsumedNone;
        end else if (in_range) begin
          status_q <= b62sc_pkg::StOk;
          val_q <= vq_q.val;
          cons_q <= b62sc_pkg::ConsumedOk;
        end else begin
          status_q <= b62sc_pkg::StRange;
          val_q <= '0;
          cons_q <= b62sc_pkg::ConsumedNone;
        end
      end else begin
        kind_q <= b62sc_pkg::KindChar;
        char_q <= row_q[0];
        last_q <= (cnt_q == RowCntW'(1));
        status_q <= b62sc_pkg::StOk;
        val_q <= '0;
        cons_q <= b62sc_pkg::ConsumedNone;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser = kind_q;
  assign m_axis_tlast = last_q;
  assign m_axis_tdata = {3'b000, cons_q, status_q, val_q, char_q};

endmodule

@@ test/tb_base62_serial_codec_unit.sv @@
`timescale 1ns / 100ps

module tb_base62_serial_codec_unit;

  localparam logic [7:0] SepChar = 8'h5F;
  localparam logic [63:0] SerialLow = 64'd3844;
  localparam logic [63:0] SerialHigh = 64'd8392993658683402240;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned ItemTarget = 170;

  typedef struct packed {
    logic        kind;
    logic [7:0]  glyph;
    logic [62:0] serial;
    logic [1:0]  status;
    logic [3:0]  consumed;
    logic        last;
  } codec_result_t;

  class codec_scoreboard;
    codec_result_t pending[$];
    logic [3:0]    dec_pos;
    logic [62:0]   dec_acc;
    int            mismatches;

    function new();
      dec_pos = '0;
      dec_acc = '0;
      mismatches = 0;
    endfunction

    function logic [7:0] glyph_of(logic [5:0] d);
      if (d < 10) return 8'h30 + 8'(d);
      if (d < 36) return 8'h61 + 8'(d) - 8'd10;
      return 8'h41 + 8'(d) - 8'd36;
    endfunction

    function int glyph_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41 + 36;
      return 62;
    endfunction

    // Character idx of the text form of a nonzero serial; idx 0 is the separator.
    function logic [7:0] serial_char(logic [63:0] v, int idx);
      logic [63:0] n;
      int k;
      if (idx == 0) return SepChar;
      n = v;
      for (k = 0; k < 11 - idx; k++) n = n / 64'd62;
      return glyph_of(6'(n % 64'd62));
    endfunction

    function void push_verdict(logic [62:0] v, logic [1:0] st, logic [3:0] cnt);
      codec_result_t r;
      r = '{b62sc_pkg::KindVerdict, 8'h00, v, st, cnt, 1'b1};
      pending.push_back(r);
      dec_pos = '0;
      dec_acc = '0;
    endfunction

    function void note_request(logic op, logic [63:0] value, logic [7:0] ch);
      codec_result_t r;
      logic [3:0] pos;
      int d;
      int i;
      if (op == b62sc_pkg::OpEncode) begin
        if (value == 0) begin
          r = '{b62sc_pkg::KindChar, SepChar, 63'd0, b62sc_pkg::StOk,
                b62sc_pkg::ConsumedNone, 1'b0};
          pending.push_back(r);
          r.last = 1'b1;
          pending.push_back(r);
        end else begin
          for (i = 0; i < 12; i++) begin
            r = '{b62sc_pkg::KindChar, serial_char(value, i), 63'd0, b62sc_pkg::StOk,
                  b62sc_pkg::ConsumedNone, i == 11};
            pending.push_back(r);
          end
        end
        return;
      end
      pos = (dec_pos > 11) ? 4'd0 : dec_pos;
      if (pos == 0) begin
        if (ch != SepChar) begin
          push_verdict(63'd0, b62sc_pkg::StMalformed, b62sc_pkg::ConsumedNone);
        end else begin
          dec_pos = 4'd1;
          dec_acc = '0;
        end
      end else if (pos == 1) begin
        if (ch == SepChar) begin
          push_verdict(63'd0, b62sc_pkg::StNil, b62sc_pkg::ConsumedNil);
        end else if (ch < 8'h30 || ch > 8'h39) begin
          push_verdict(63'd0, b62sc_pkg::StMalformed, b62sc_pkg::ConsumedNone);
        end else begin
          dec_acc = 63'(ch - 8'h30);
          dec_pos = 4'd2;
        end
      end else begin
        d = glyph_value(ch);
        if (d >= 62) begin
          push_verdict(63'd0, b62sc_pkg::StMalformed, b62sc_pkg::ConsumedNone);
        end else begin
          dec_acc = 63'(64'(dec_acc) * 64'd62 + 64'(d));
          if (pos < 11) begin
            dec_pos = pos + 4'd1;
          end else if (64'(dec_acc) > SerialLow && 64'(dec_acc) < SerialHigh) begin
            push_verdict(dec_acc, b62sc_pkg::StOk, b62sc_pkg::ConsumedOk);
          end else begin
            push_verdict(63'd0, b62sc_pkg::StRange, b62sc_pkg::ConsumedNone);
          end
        end
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(logic [79:0] data, logic kind, logic last);
      codec_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", data[63:0], 64'd0);
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) report_mismatch("kind", 64'(kind), 64'(want.kind));
      if (data[7:0] !== want.glyph) report_mismatch("out_char", 64'(data[7:0]), 64'(want.glyph));
      if (data[70:8] !== want.serial) begin
        report_mismatch("decoded_value", 64'(data[70:8]), 64'(want.serial));
      end
      if (data[72:71] !== want.status) begin
        report_mismatch("status", 64'(data[72:71]), 64'(want.status));
      end
      if (data[76:73] !== want.consumed) begin
        report_mismatch("consumed", 64'(data[76:73]), 64'(want.consumed));
      end
      if (data[79:77] !== 3'b000) report_mismatch("padding", 64'(data[79:77]), 64'd0);
      if (last !== want.last) report_mismatch("last", 64'(last), 64'(want.last));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [b62sc_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [b62sc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  codec_scoreboard sb;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  bit              tx_gappy = 1'b1;
  bit              rx_gappy = 1'b1;

  base62_serial_codec_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  task send_request(logic op, logic [63:0] value, logic [7:0] ch);
    int gap;
    gap = tx_gappy ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ch, value};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, value, ch);
    items_sent++;
  endtask

  task send_encode(logic [63:0] value);
    send_request(b62sc_pkg::OpEncode, value, 8'($urandom_range(0, 255)));
  endtask

  task send_decode(logic [7:0] ch);
    send_request(b62sc_pkg::OpDecode, {$urandom, $urandom}, ch);
  endtask

  task send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_decode(s[i]);
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_gappy = !rx_gappy;
      stall = rx_gappy ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    logic [63:0] v;
    int pick;
    int spoil;
    int i;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_encode(64'd0);
    send_encode(64'd1);
    send_encode(64'hFFFF_FFFF_FFFF_FFFF);
    send_encode(SerialHigh - 64'd1);
    send_decode(8'h00);
    send_text("__");
    send_text("_a");
    send_text("_5!");
    for (i = 0; i < 12; i++) begin
      if (i == 6) send_encode(64'h8000_0000_0000_0000);
      send_decode(sb.serial_char(SerialLow, i));
    end

    while (items_sent < ItemTarget) begin
      tx_gappy = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        case ($urandom_range(0, 5))
          0: v = SerialLow + 64'd1;
          1: v = SerialHigh - 64'd1;
          2: v = 64'($urandom_range(0, 3844));
          default: v = ({$urandom, $urandom} % (SerialHigh - SerialLow - 64'd1)) + SerialLow + 64'd1;
        endcase
        spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : 12;
        for (i = 0; i < 12; i++) begin
          if ($urandom_range(0, 15) == 0) send_encode({$urandom, $urandom});
          send_decode(i == spoil ? 8'($urandom_range(0, 255)) : sb.serial_char(v, i));
        end
      end else if (pick == 5) begin
        send_text("__");
      end else if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = 64'($urandom_range(1, 3844));
          default: v = {$urandom, $urandom};
        endcase
        send_encode(v);
      end else begin
        repeat ($urandom_range(1, 3)) send_decode(8'($urandom_range(0, 255)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
